>>> design/rrc_pkg.sv
`timescale 1ns / 1ps

package rrc_pkg;

  // Defaults for the top-level parameters
  localparam int COORD_WIDTH_DEF = 24;
  localparam int TRIG_BITS_DEF = 16;

  // Fixed field and datapath widths
  localparam int ANGLE_W = 13;
  localparam int TURN_W = 12;          // reduced angle, -1440..1440
  localparam int CORDIC_W = 34;        // Q2.30 plus headroom
  localparam int CORDIC_MAX_ITER = 24;
  localparam int CFG_INDEX_W = 1;
  localparam int CORNER_W = 2;

  // Angle units are 1/16 degree
  localparam logic signed [ANGLE_W:0] ANGLE_FULL = 14'sd5760;
  localparam logic signed [ANGLE_W:0] ANGLE_HALF = 14'sd2880;
  localparam logic signed [ANGLE_W:0] ANGLE_QUARTER = 14'sd1440;

  localparam logic signed [21:0] RAD_PER_UNIT_Q30 = 22'sd1171271;

  typedef logic signed [CORDIC_W-1:0] cordic_word_t;

  localparam cordic_word_t CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam cordic_word_t ATAN_Q30 [0:CORDIC_MAX_ITER-1] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048575,   34'sd524287,
    34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
    34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
    34'sd1023,      34'sd511,       34'sd255,       34'sd127
  };

  // 50.0 in Q16.8
  localparam int RECT_DIM_RESET = 12800;

  // Register map
  localparam logic [CFG_INDEX_W-1:0] REG_RECT_WIDTH = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RECT_HEIGHT = 1'd1;

  localparam logic [CORNER_W-1:0] LAST_CORNER = 2'd3;

  // Angle folding flags carried alongside the rotation
  typedef struct packed {
    logic flip;   // negate sine and cosine
    logic zero;   // exact unrotated corners
  } rrc_flags_t;

endpackage

>>> design/rrc_prep.sv
`timescale 1ns / 1ps

module rrc_prep import rrc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic signed [COORD_WIDTH-1:0] pos_z,
  input  logic        [ANGLE_W-1:0]     angle_deg,
  output logic                         out_valid,
  output cordic_word_t                 out_z,
  output rrc_flags_t                   out_flags,
  output logic [3*COORD_WIDTH-1:0]     out_data
);

  localparam int DATA_W = 3 * COORD_WIDTH;

  logic signed [ANGLE_W:0]  a_ext;
  logic signed [ANGLE_W:0]  a_red;
  logic signed [ANGLE_W:0]  t_half;
  logic signed [ANGLE_W:0]  t_fold;
  rrc_flags_t               flags_next;

  logic                     a_valid;
  logic signed [TURN_W-1:0] a_turn;
  rrc_flags_t               a_flags;
  logic [DATA_W-1:0]        a_data;
  cordic_word_t             z_prod;

  // Fold the angle into [-90, 90] degrees, flip sign for the outer half turn
  always_comb begin
    a_ext = $signed({1'b0, angle_deg});
    a_red = (a_ext >= ANGLE_FULL) ? a_ext - ANGLE_FULL : a_ext;
    t_half = (a_red > ANGLE_HALF) ? a_red - ANGLE_FULL : a_red;
    flags_next.zero = (a_red == '0);
    flags_next.flip = 1'b0;
    t_fold = t_half;
    if (t_half > ANGLE_QUARTER) begin
      t_fold = t_half - ANGLE_HALF;
      flags_next.flip = 1'b1;
    end else if (t_half < -ANGLE_QUARTER) begin
      t_fold = t_half + ANGLE_HALF;
      flags_next.flip = 1'b1;
    end
  end

  assign z_prod = CORDIC_W'(a_turn) * CORDIC_W'(RAD_PER_UNIT_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_turn <= t_fold[TURN_W-1:0];
      a_flags <= flags_next;
      a_data <= {pos_x, pos_y, pos_z};
      out_z <= z_prod;
      out_flags <= a_flags;
      out_data <= a_data;
    end
  end

endmodule

>>> design/rrc_cell.sv
`timescale 1ns / 1ps

module rrc_cell import rrc_pkg::*; #(
  parameter int STAGE = 0,
  parameter int DATA_W = 3 * COORD_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  cordic_word_t      in_x,
  input  cordic_word_t      in_y,
  input  cordic_word_t      in_z,
  input  rrc_flags_t        in_flags,
  input  logic [DATA_W-1:0] in_data,
  output logic              out_valid,
  output cordic_word_t      out_x,
  output cordic_word_t      out_y,
  output cordic_word_t      out_z,
  output rrc_flags_t        out_flags,
  output logic [DATA_W-1:0] out_data
);

  cordic_word_t x_next;
  cordic_word_t y_next;
  cordic_word_t z_next;

  // One micro-rotation toward zero residual angle
  always_comb begin
    if (!in_z[CORDIC_W-1]) begin
      x_next = in_x - (in_y >>> STAGE);
      y_next = in_y + (in_x >>> STAGE);
      z_next = in_z - ATAN_Q30[STAGE];
    end else begin
      x_next = in_x + (in_y >>> STAGE);
      y_next = in_y - (in_x >>> STAGE);
      z_next = in_z + ATAN_Q30[STAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x <= x_next;
      out_y <= y_next;
      out_z <= z_next;
      out_flags <= in_flags;
      out_data <= in_data;
    end
  end

endmodule

>>> design/rrc_corner.sv
`timescale 1ns / 1ps

module rrc_corner import rrc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int TRIG_BITS = TRIG_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  cordic_word_t                  in_x,
  input  cordic_word_t                  in_y,
  input  rrc_flags_t                    in_flags,
  input  logic [3*COORD_WIDTH-1:0]      in_data,
  input  logic [COORD_WIDTH-2:0]        rect_width,
  input  logic [COORD_WIDTH-2:0]        rect_height,
  input  logic                          out_stall,
  output logic                          adv,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] corner_x,
  output logic signed [COORD_WIDTH-1:0] corner_y,
  output logic signed [COORD_WIDTH-1:0] corner_z,
  output logic [CORNER_W-1:0]           corner_index,
  output logic                          last
);

  localparam int CW = COORD_WIDTH;
  localparam int FB = TRIG_BITS - 2;
  localparam int RSH = 32 - TRIG_BITS;
  localparam int PW = COORD_WIDTH + TRIG_BITS;
  localparam int SW = COORD_WIDTH + TRIG_BITS + 1;
  localparam logic signed [TRIG_BITS-1:0] TRIG_ONE = TRIG_BITS'(2 ** FB);
  localparam logic signed [SW-1:0] ROUND_ONE = SW'(2 ** FB);
  localparam cordic_word_t TRIG_ROUND = CORDIC_W'(2 ** (RSH - 1));

  function automatic logic signed [CW-1:0] sat(input logic signed [CW+1:0] v);
    logic [2:0] top;
    top = v[CW+1:CW-1];
    if (top == 3'b000 || top == 3'b111) begin
      return v[CW-1:0];
    end else if (v[CW+1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  // Trig / base stage
  cordic_word_t                 x_rnd;
  cordic_word_t                 y_rnd;
  logic signed [TRIG_BITS-1:0]  c_rnd;
  logic signed [TRIG_BITS-1:0]  s_rnd;
  logic signed [TRIG_BITS-1:0]  c_next;
  logic signed [TRIG_BITS-1:0]  s_next;
  logic signed [CW-1:0]         px;
  logic signed [CW-1:0]         py;
  logic signed [CW+1:0]         cx2;
  logic signed [CW+1:0]         cy2;

  logic                         t_valid;
  logic signed [TRIG_BITS-1:0]  t_c;
  logic signed [TRIG_BITS-1:0]  t_s;
  logic signed [SW-1:0]         t_bx;
  logic signed [SW-1:0]         t_by;
  logic signed [CW-1:0]         t_z;

  // Product stage
  logic signed [PW-1:0]         w_ext;
  logic signed [PW-1:0]         h_ext;
  logic signed [PW-1:0]         c_ext;
  logic signed [PW-1:0]         s_ext;

  logic                         m_valid;
  logic signed [PW-1:0]         m_wc;
  logic signed [PW-1:0]         m_ws;
  logic signed [PW-1:0]         m_hc;
  logic signed [PW-1:0]         m_hs;
  logic signed [SW-1:0]         m_bx;
  logic signed [SW-1:0]         m_by;
  logic signed [CW-1:0]         m_z;

  // Corner sequencer
  logic [CORNER_W-1:0]          k;
  logic                         load;
  logic                         sx_pos;
  logic                         sy_pos;
  logic signed [PW-1:0]         term_wc;
  logic signed [PW-1:0]         term_hs;
  logic signed [PW-1:0]         term_ws;
  logic signed [PW-1:0]         term_hc;
  logic signed [SW-1:0]         sum_x;
  logic signed [SW-1:0]         sum_y;

  // Round CORDIC outputs to FB fraction bits, apply folding
  always_comb begin
    x_rnd = in_x + TRIG_ROUND;
    y_rnd = in_y + TRIG_ROUND;
    c_rnd = x_rnd[RSH+TRIG_BITS-1:RSH];
    s_rnd = y_rnd[RSH+TRIG_BITS-1:RSH];
    if (in_flags.zero) begin
      c_next = TRIG_ONE;
      s_next = '0;
    end else if (in_flags.flip) begin
      c_next = -c_rnd;
      s_next = -s_rnd;
    end else begin
      c_next = c_rnd;
      s_next = s_rnd;
    end
    px = in_data[3*CW-1:2*CW];
    py = in_data[2*CW-1:CW];
    // doubled center coordinates
    cx2 = $signed({px[CW-1], px, 1'b0}) + $signed({3'b000, rect_width});
    cy2 = $signed({py[CW-1], py, 1'b0}) + $signed({3'b000, rect_height});
  end

  always_comb begin
    w_ext = PW'($signed({1'b0, rect_width}));
    h_ext = PW'($signed({1'b0, rect_height}));
    c_ext = PW'(t_c);
    s_ext = PW'(t_s);
  end

  assign load = m_valid && (!out_valid || !out_stall);
  assign adv = !m_valid || (load && (k == LAST_CORNER));

  // Corner k: x offset negative for 0,1; y offset negative for 0,3
  always_comb begin
    sx_pos = k[1];
    sy_pos = k[1] ^ k[0];
    term_wc = sx_pos ? m_wc : -m_wc;
    term_hs = sy_pos ? -m_hs : m_hs;
    term_ws = sx_pos ? m_ws : -m_ws;
    term_hc = sy_pos ? m_hc : -m_hc;
    sum_x = m_bx + SW'(term_wc) + SW'(term_hs);
    sum_y = m_by + SW'(term_ws) + SW'(term_hc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
      m_valid <= 1'b0;
    end else if (adv) begin
      t_valid <= in_valid;
      m_valid <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_c <= c_next;
      t_s <= s_next;
      t_bx <= (SW'(cx2) <<< FB) + ROUND_ONE;
      t_by <= (SW'(cy2) <<< FB) + ROUND_ONE;
      t_z <= in_data[CW-1:0];
      m_wc <= w_ext * c_ext;
      m_ws <= w_ext * s_ext;
      m_hc <= h_ext * c_ext;
      m_hs <= h_ext * s_ext;
      m_bx <= t_bx;
      m_by <= t_by;
      m_z <= t_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      k <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      k <= k + 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      corner_x <= sat(sum_x[SW-1:FB+1]);
      corner_y <= sat(sum_y[SW-1:FB+1]);
      corner_z <= m_z;
      corner_index <= k;
      last <= (k == LAST_CORNER);
    end
  end

endmodule

>>> design/rotated_rect_corners.sv
`timescale 1ns / 1ps

// Rotated rectangle corner generator.
// Input channel (in_valid / in_stall): one request carries an origin pos_x,
// pos_y, a depth pos_z (signed Q16.8) and angle_deg in 1/16 degree units.
// Output channel (out_valid / out_stall): four requests per input, corners
// (x,y), (x,y+h), (x+w,y+h), (x+w,y) with corner_index 0..3 and last on the
// fourth; corner_z repeats pos_z. Nonzero angles rotate about the center.
// Config port: cfg_write with cfg_index 0 = rect_width, 1 = rect_height
// (unsigned Q15.8); write only while no request is in flight.
// The first corner passes the prep registers, the CORDIC cell row, the trig
// and product stages and the corner output register; the rest follow one
// per cycle when not stalled. Input rate is set by the single corner output
// register, which emits four corners per input; the CORDIC cell row takes a
// new angle every cycle only while the product stage is empty or loads its
// last corner, and holds its items frozen while the corners drain.
// Reset clears all valid flags and the corner counter and loads both
// dimensions with 50.0. While out_stall is high the presented corner holds;
// the whole pipeline freezes while its last stage still owes corners, and
// in_stall rises.
module rotated_rect_corners import rrc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int TRIG_BITS = TRIG_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [COORD_WIDTH-2:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic signed [COORD_WIDTH-1:0] pos_z,
  input  logic [ANGLE_W-1:0]            angle_deg,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] corner_x,
  output logic signed [COORD_WIDTH-1:0] corner_y,
  output logic signed [COORD_WIDTH-1:0] corner_z,
  output logic [CORNER_W-1:0]           corner_index,
  output logic                          last
);

  localparam int DATA_W = 3 * COORD_WIDTH;

  logic [COORD_WIDTH-2:0] rect_width;
  logic [COORD_WIDTH-2:0] rect_height;

  // Global advance: every stage moves together unless the final stage
  // still owes corners
  logic adv;

  logic              cv [0:TRIG_BITS];
  cordic_word_t      cx [0:TRIG_BITS];
  cordic_word_t      cy [0:TRIG_BITS];
  cordic_word_t      cz [0:TRIG_BITS];
  rrc_flags_t        cf [0:TRIG_BITS];
  logic [DATA_W-1:0] cd [0:TRIG_BITS];

  assign in_stall = !adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_width <= (COORD_WIDTH-1)'(RECT_DIM_RESET);
      rect_height <= (COORD_WIDTH-1)'(RECT_DIM_RESET);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RECT_WIDTH: rect_width <= cfg_data;
        REG_RECT_HEIGHT: rect_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Angle folding and conversion to radians
  rrc_prep #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_prep (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .in_valid(in_valid),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .pos_z(pos_z),
    .angle_deg(angle_deg),
    .out_valid(cv[0]),
    .out_z(cz[0]),
    .out_flags(cf[0]),
    .out_data(cd[0])
  );

  // Start every rotation from the gain-compensated unit vector
  assign cx[0] = CORDIC_GAIN_Q30;
  assign cy[0] = '0;

  // Row of CORDIC cells, one micro-rotation each
  for (genvar i = 0; i < TRIG_BITS; i++) begin : g_cell
    rrc_cell #(
      .STAGE(i),
      .DATA_W(DATA_W)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .adv(adv),
      .in_valid(cv[i]),
      .in_x(cx[i]),
      .in_y(cy[i]),
      .in_z(cz[i]),
      .in_flags(cf[i]),
      .in_data(cd[i]),
      .out_valid(cv[i+1]),
      .out_x(cx[i+1]),
      .out_y(cy[i+1]),
      .out_z(cz[i+1]),
      .out_flags(cf[i+1]),
      .out_data(cd[i+1])
    );
  end

  // Round trig values, form offsets, emit four corners
  rrc_corner #(
    .COORD_WIDTH(COORD_WIDTH),
    .TRIG_BITS(TRIG_BITS)
  ) u_corner (
    .clk(clk),
    .rst(rst),
    .in_valid(cv[TRIG_BITS]),
    .in_x(cx[TRIG_BITS]),
    .in_y(cy[TRIG_BITS]),
    .in_flags(cf[TRIG_BITS]),
    .in_data(cd[TRIG_BITS]),
    .rect_width(rect_width),
    .rect_height(rect_height),
    .out_stall(out_stall),
    .adv(adv),
    .out_valid(out_valid),
    .corner_x(corner_x),
    .corner_y(corner_y),
    .corner_z(corner_z),
    .corner_index(corner_index),
    .last(last)
  );

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

// Bench for the rotated rectangle corner generator.
// A queue of pending requests feeds a driver that changes inputs on the
// falling edge; a monitor on the rising edge predicts four corners for every
// request the block takes and checks each corner the block hands out.
module tb;
  import rrc_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int FRAC = TRIG_BITS_DEF - 2;           // fraction bits of sin/cos
  localparam int ROT_STEPS = (TRIG_BITS_DEF < 24) ? TRIG_BITS_DEF : 24;
  localparam int TURN_FULL = 5760;                   // 360 degrees in 1/16 units
  localparam int TURN_HALF = 2880;
  localparam int TURN_QUARTER = 1440;
  localparam longint UNIT_RAD_Q30 = 1171271;         // pi/2880 in Q30
  localparam longint CORDIC_K_Q30 = 652032874;       // inverse CORDIC gain
  localparam logic [CW-2:0] DIM_MAX = '1;
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam int RUN_LIMIT = 400000;

  localparam longint ARCTAN_Q30 [0:23] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [ANGLE_W-1:0]   ang;
  } rect_req_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [CORNER_W-1:0]  idx;
    logic                 last;
  } corner_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CW-2:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] pos_x = '0;
  logic signed [CW-1:0] pos_y = '0;
  logic signed [CW-1:0] pos_z = '0;
  logic [ANGLE_W-1:0] angle_deg = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CW-1:0] corner_x;
  logic signed [CW-1:0] corner_y;
  logic signed [CW-1:0] corner_z;
  logic [CORNER_W-1:0] corner_index;
  logic last;

  rotated_rect_corners dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .angle_deg(angle_deg),
    .out_valid(out_valid), .out_stall(out_stall),
    .corner_x(corner_x), .corner_y(corner_y), .corner_z(corner_z),
    .corner_index(corner_index), .last(last)
  );

  always #6 clk = ~clk;

  // Bench copy of the two size registers; only touched while the block idles.
  logic [CW-2:0] rect_w = (CW-1)'(RECT_DIM_RESET);
  logic [CW-2:0] rect_h = (CW-1)'(RECT_DIM_RESET);

  rect_req_t req_queue[$];      // requests waiting for the driver
  corner_t   corner_due[$];     // predicted corners, oldest first
  corner_t   want;

  int  idle_pct = 0;            // chance per cycle to start an idle burst
  int  in_gap = 0;
  int  out_gap = 0;
  bit  req_taken = 0;
  int  errors = 0;
  int  cycles = 0;
  int  rects_sent = 0;
  int  rects_rotated = 0;
  int  rects_wrapped = 0;
  int  corners_checked = 0;
  int  size_settings = 1;

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Sine and cosine with FRAC fraction bits for a reduced, nonzero angle.
  function automatic void rotation_trig(input int ang, output longint sin_q,
                                        output longint cos_q);
    longint t, xr, yr, zr, xn;
    bit flip;
    t = ang;
    flip = 0;
    xr = CORDIC_K_Q30;
    yr = 0;
    // Fold into [-90, 90] degrees; the outer half turn negates both results.
    if (t > TURN_HALF) t -= TURN_FULL;
    if (t > TURN_QUARTER) begin
      t -= TURN_HALF;
      flip = 1;
    end else if (t < -TURN_QUARTER) begin
      t += TURN_HALF;
      flip = 1;
    end
    zr = t * UNIT_RAD_Q30;
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (zr >= 0) begin
        xn = xr - (yr >>> i);
        yr = yr + (xr >>> i);
        zr -= ARCTAN_Q30[i];
      end else begin
        xn = xr + (yr >>> i);
        yr = yr - (xr >>> i);
        zr += ARCTAN_Q30[i];
      end
      xr = xn;
    end
    // Round half up down to FRAC bits.
    xr = (xr + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
    yr = (yr + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
    cos_q = flip ? -xr : xr;
    sin_q = flip ? -yr : yr;
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(input longint v);
    if (v > longint'(COORD_MAX)) return COORD_MAX;
    if (v < longint'(COORD_MIN)) return COORD_MIN;
    return v[CW-1:0];
  endfunction

  // Queue the four corners a request must produce under the current sizes.
  function automatic void predict_corners(input rect_req_t r);
    longint px, py, w, h, s, c, one, dx, dy, ax, ay, cx, cy;
    int ang;
    bit up, right;
    corner_t e;
    px = r.x;
    py = r.y;
    w = rect_w;
    h = rect_h;
    ang = r.ang;
    s = 0;
    c = 0;
    if (ang >= TURN_FULL) ang -= TURN_FULL;
    if (ang != 0) rotation_trig(ang, s, c);
    one = 64'sd1 <<< FRAC;
    for (int k = 0; k < 4; k++) begin
      right = (k >= 2);
      up = (k == 1 || k == 2);
      if (ang == 0) begin
        cx = px + (right ? w : 0);
        cy = py + (up ? h : 0);
      end else begin
        // Offsets from the center in doubled units keep the half bit.
        dx = right ? w : -w;
        dy = up ? h : -h;
        ax = (2 * px + w) * one + dx * c - dy * s + one;
        ay = (2 * py + h) * one + dx * s + dy * c + one;
        cx = ax >>> (FRAC + 1);
        cy = ay >>> (FRAC + 1);
      end
      e.x = clamp_coord(cx);
      e.y = clamp_coord(cy);
      e.z = r.z;
      e.idx = CORNER_W'(k);
      e.last = (e.idx == LAST_CORNER);
      corner_due.push_back(e);
    end
  endfunction

  task automatic check_field(input string name, input logic signed [CW-1:0] exp_v,
                             input logic signed [CW-1:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: present requests and stall the output side, both at the
  // falling edge. A presented request holds until it is taken.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || req_taken) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
          in_gap = $urandom_range(3);
          in_valid <= 1'b0;
        end else if (req_queue.size() != 0) begin
          rect_req_t nxt;
          nxt = req_queue.pop_front();
          pos_x <= nxt.x;
          pos_y <= nxt.y;
          pos_z <= nxt.z;
          angle_deg <= nxt.ang;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        out_gap = $urandom_range(3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: predict on every accepted request, check every accepted corner.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    req_taken = 0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        rect_req_t got;
        got.x = pos_x;
        got.y = pos_y;
        got.z = pos_z;
        got.ang = angle_deg;
        req_taken = 1;
        rects_sent++;
        if (angle_deg >= ANGLE_W'(TURN_FULL)) rects_wrapped++;
        if (angle_deg != 0 && angle_deg != ANGLE_W'(TURN_FULL)) rects_rotated++;
        predict_corners(got);
      end
      if (out_valid && !out_stall) begin
        if (corner_due.size() == 0) begin
          errors++;
          $display("%0t: corner with nothing expected, actual x=%0d y=%0d index=%0d",
                   $time, corner_x, corner_y, corner_index);
        end else begin
          want = corner_due.pop_front();
          corners_checked++;
          check_field("corner_x", want.x, corner_x);
          check_field("corner_y", want.y, corner_y);
          check_field("corner_z", want.z, corner_z);
          check_field("corner_index", CW'(want.idx), CW'(corner_index));
          check_field("last", CW'(want.last), CW'(last));
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("%0t: timeout with %0d corners outstanding", $time, corner_due.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic logic signed [CW-1:0] pick_coord();
    logic signed [CW-1:0] v;
    int unsigned sel;
    sel = $urandom_range(9);
    v = CW'($urandom);
    if (sel < 5) begin
      v = v >>> 7;                   // keep half the origins near zero
    end else if (sel == 9) begin
      v = $urandom_range(1) ? COORD_MAX - CW'($urandom_range(300))
                            : COORD_MIN + CW'($urandom_range(300));
    end
    return v;
  endfunction

  function automatic logic [ANGLE_W-1:0] pick_angle();
    int unsigned sel;
    sel = $urandom_range(19);
    if (sel == 0) return '0;
    if (sel <= 2) return ANGLE_W'($urandom_range(TURN_FULL, 8191));
    if (sel == 3) return ANGLE_W'(TURN_QUARTER * $urandom_range(1, 3) + $urandom_range(2) - 1);
    return ANGLE_W'($urandom_range(1, TURN_FULL - 1));
  endfunction

  function automatic logic [CW-2:0] pick_dim();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 6) return (CW-1)'($urandom_range(1, 40000));
    if (sel < 9) return (CW-1)'($urandom);
    return sel[0] ? DIM_MAX : '0;
  endfunction

  task automatic add_req(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                         input logic signed [CW-1:0] z, input int ang);
    rect_req_t r;
    r.x = x;
    r.y = y;
    r.z = z;
    r.ang = ANGLE_W'(ang);
    req_queue.push_back(r);
  endtask

  task automatic add_random_reqs(input int n);
    repeat (n) add_req(pick_coord(), pick_coord(), CW'($urandom), pick_angle());
  endtask

  // Hold until every request is taken and every corner has come back.
  task automatic wait_idle();
    while (req_queue.size() != 0 || in_valid || corner_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_size(input logic [CW-2:0] w, input logic [CW-2:0] h);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_RECT_WIDTH;
    cfg_data <= w;
    @(negedge clk);
    cfg_index <= REG_RECT_HEIGHT;
    cfg_data <= h;
    @(negedge clk);
    cfg_write <= 1'b0;
    rect_w = w;
    rect_h = h;
    size_settings++;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed: reset sizes, exact path, every quadrant edge, wrapped angles.
    idle_pct = 30;
    add_req('0, '0, '0, 0);
    add_req(COORD_MAX, COORD_MAX, COORD_MAX, 0);
    add_req(COORD_MIN, COORD_MIN, COORD_MIN, 0);
    add_req(CW'(2560), -CW'(1280), CW'(77), 1);
    add_req(CW'(2560), CW'(512), '1, 720);
    add_req('0, '0, '0, TURN_QUARTER - 1);
    add_req('0, '0, '0, TURN_QUARTER);
    add_req('0, '0, '0, TURN_QUARTER + 1);
    add_req(-CW'(700), CW'(300), '0, TURN_HALF);
    add_req(-CW'(700), CW'(300), '0, TURN_HALF + 1);
    add_req(CW'(99), CW'(99), '0, 3 * TURN_QUARTER);
    add_req(CW'(99), CW'(99), '0, TURN_FULL - 1);
    add_req(CW'(1000), CW'(2000), CW'(5), TURN_FULL);     // wraps to zero: exact
    add_req(CW'(1000), CW'(2000), CW'(5), 8191);
    add_req(COORD_MAX, COORD_MIN, '0, 2000);
    wait_idle();

    // Degenerate rectangle: every corner sits on the origin or its rotation.
    set_size('0, '0);
    add_req(CW'(4321), -CW'(4321), '0, 0);
    add_req(CW'(4321), -CW'(4321), '0, 1000);
    add_req(COORD_MAX, COORD_MAX, '0, 2000);
    wait_idle();

    // Widest rectangle: drive the corners into saturation.
    set_size(DIM_MAX, DIM_MAX);
    add_req('0, '0, '0, 0);
    add_req(COORD_MIN, COORD_MIN, '0, 0);
    add_req('0, '0, '0, TURN_HALF);
    add_req(COORD_MIN, COORD_MAX, '0, 720);
    wait_idle();

    // Random phases, each under its own sizes and idling.
    set_size((CW-1)'(1), DIM_MAX);
    add_random_reqs(76);
    wait_idle();

    idle_pct = 0;
    set_size(pick_dim(), pick_dim());
    add_random_reqs(76);
    wait_idle();

    // Heavy idling, with a full drain halfway through.
    idle_pct = 60;
    set_size(pick_dim(), pick_dim());
    add_random_reqs(38);
    wait_idle();
    add_random_reqs(38);
    wait_idle();

    idle_pct = 20;
    set_size(DIM_MAX, '0);
    add_random_reqs(76);
    wait_idle();

    // Back to the reset sizes at full rate, no idling to the end.
    idle_pct = 0;
    set_size((CW-1)'(RECT_DIM_RESET), (CW-1)'(RECT_DIM_RESET));
    add_random_reqs(76);
    wait_idle();

    repeat (40) @(posedge clk);
    if (corner_due.size() != 0) begin
      errors++;
      $display("%0t: %0d corners never arrived", $time, corner_due.size());
    end

    $display("Sent %0d rectangles (%0d rotated, %0d with wrapped angles) over %0d sizes",
             rects_sent, rects_rotated, rects_wrapped, size_settings);
    $display("Checked %0d corners, %0d field errors", corners_checked, errors);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/rrc_pkg.sv
design/rrc_prep.sv
design/rrc_cell.sv
design/rrc_corner.sv
design/rotated_rect_corners.sv
bench/tb.sv
